[src/letter_bigram_markov_sampler_top_assert.svh]
// Assertion macros used by the sampler top module.
`ifndef LETTER_BIGRAM_MARKOV_SAMPLER_TOP_ASSERT_SVH
`define LETTER_BIGRAM_MARKOV_SAMPLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lbms_pkg.sv]
package lbms_pkg;

    localparam int ALPHABET_DEF   = 52;
    localparam int COUNT_BITS_DEF = 32;

    // Width of the random word reduced by the remainder unit.
    localparam int RND_BITS = 32;

    localparam logic [1:0] FUNC_COUNT  = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  first_letter;
        logic [5:0]  second_letter;
        logic [31:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  letter_out;
        logic [31:0] pair_count;
        logic [31:0] row_total;
        logic [1:0]  status;
    } t_out_item;

    // Access request from the sequencer to the count tables.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_tbl_ctl;

endpackage

[src/lbms_table.sv]
module lbms_table #(
    parameter int ALPHABET   = lbms_pkg::ALPHABET_DEF,
    parameter int COUNT_BITS = lbms_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbms_pkg::t_tbl_ctl           i_ctl,
    input  logic [$clog2(ALPHABET*ALPHABET)-1:0] i_pc_addr,
    input  logic [$clog2(ALPHABET)-1:0]  i_row_addr,
    input  logic [COUNT_BITS-1:0]        i_pc_wdata,
    input  logic [COUNT_BITS-1:0]        i_rt_wdata,
    output logic [COUNT_BITS-1:0]        o_pc_rdata,
    output logic [COUNT_BITS-1:0]        o_rt_rdata,
    output logic                         o_clr_busy
);

    localparam int PAIR_DEPTH = ALPHABET * ALPHABET;
    localparam int AW         = $clog2(PAIR_DEPTH);
    localparam int RAW        = $clog2(ALPHABET);

    logic [COUNT_BITS-1:0] r_pc_mem [PAIR_DEPTH];
    logic [COUNT_BITS-1:0] r_rt_mem [ALPHABET];
    logic [COUNT_BITS-1:0] r_pc_rdata;
    logic [COUNT_BITS-1:0] r_rt_rdata;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_clr_busy;

    logic                  w_pc_we;
    logic                  w_rt_we;
    logic [AW-1:0]         w_pc_waddr;
    logic [RAW-1:0]        w_rt_waddr;
    logic [COUNT_BITS-1:0] w_pc_wd;
    logic [COUNT_BITS-1:0] w_rt_wd;

    // During the clearing pass every pair entry is zeroed, and the row entries
    // are zeroed alongside the first ALPHABET addresses.
    always_comb begin
        if (r_clr_busy) begin
            w_pc_we    = 1'b1;
            w_pc_waddr = r_clr_addr;
            w_pc_wd    = '0;
            w_rt_we    = (r_clr_addr < AW'(ALPHABET));
            w_rt_waddr = r_clr_addr[RAW-1:0];
            w_rt_wd    = '0;
        end else begin
            w_pc_we    = i_ctl.wr;
            w_pc_waddr = i_pc_addr;
            w_pc_wd    = i_pc_wdata;
            w_rt_we    = i_ctl.wr;
            w_rt_waddr = i_row_addr;
            w_rt_wd    = i_rt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(PAIR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pc_we) begin
            r_pc_mem[w_pc_waddr] <= w_pc_wd;
        end
        if (i_ctl.rd) begin
            r_pc_rdata <= r_pc_mem[i_pc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rt_we) begin
            r_rt_mem[w_rt_waddr] <= w_rt_wd;
        end
        if (i_ctl.rd) begin
            r_rt_rdata <= r_rt_mem[i_row_addr];
        end
    end

    assign o_pc_rdata = r_pc_rdata;
    assign o_rt_rdata = r_rt_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

[src/lbms_mod.sv]
module lbms_mod #(
    parameter int COUNT_BITS = lbms_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lbms_pkg::RND_BITS-1:0] i_dividend,
    input  logic [COUNT_BITS-1:0]         i_divisor,
    output logic                          o_done,
    output logic [COUNT_BITS-1:0]         o_rem
);

    localparam int RB = lbms_pkg::RND_BITS;
    localparam int CW = $clog2(RB);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [RB-1:0]   r_dvd;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS-1:0] r_rem;

    logic [COUNT_BITS:0]   w_sh;
    logic [COUNT_BITS-1:0] n_rem;

    // Restoring remainder, one dividend bit per cycle, most significant first.
    always_comb begin
        w_sh = {r_rem, r_dvd[RB-1]};
        if (w_sh >= {1'b0, r_div}) begin
            n_rem = COUNT_BITS'(w_sh - {1'b0, r_div});
        end else begin
            n_rem = w_sh[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(RB - 1);
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[RB-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[src/letter_bigram_markov_sampler_top.sv]
// Letter bigram Markov sampler.
// Items enter on the input channel (i_in_valid / o_in_ready / i_in_data) and
// each one produces exactly one result transfer on the output channel
// (o_out_valid / i_out_ready / o_out_data), in order. A count item adds one
// to a letter pair and its row total unless the row total is saturated, a
// read item returns both counters, and a sample item draws the next letter
// from the row of the current letter. Items are processed one at a time. A
// sample first runs the bit-serial remainder unit that reduces the random
// word by the row total, then walks one row entry per cycle from the pair
// count memory, whose single read port sets the walk pace. Items with an
// out-of-range letter that they use, or with an unused function code, skip
// the tables. The next item can transfer in on the same edge as the earliest
// result transfer. After reset the block runs a clearing pass over all
// ALPHABET*ALPHABET pair addresses that zeroes both tables; o_in_ready stays
// low until it ends. A finished result waits in the output register while the
// receiver stalls; the next item may be taken meanwhile, and its result is
// held internally until the output register frees up.
module letter_bigram_markov_sampler_top #(
    parameter int ALPHABET   = lbms_pkg::ALPHABET_DEF,
    parameter int COUNT_BITS = lbms_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lbms_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lbms_pkg::t_out_item o_out_data
);

`include "letter_bigram_markov_sampler_top_assert.svh"

    localparam int AW    = $clog2(ALPHABET * ALPHABET);
    localparam int RAW   = $clog2(ALPHABET);
    localparam int RUN_W = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_RD,
        S_RT,
        S_DIV,
        S_WALK,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [1:0]          r_func;
    logic [5:0]          r_a;
    logic [5:0]          r_b;
    logic [31:0]         r_rnd;
    logic [AW-1:0]       r_base;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_draw;
    logic [RUN_W-1:0]    r_run;
    logic [RAW:0]        r_j;
    logic [RAW-1:0]      r_chk_j;
    logic                r_chk_v;
    lbms_pkg::t_out_item r_res;
    lbms_pkg::t_out_item r_out;
    logic                r_out_valid;

    lbms_pkg::t_tbl_ctl  w_ctl;
    logic [AW-1:0]       w_pc_addr;
    logic [RAW-1:0]      w_row_addr;
    logic [COUNT_BITS-1:0] w_pc_rdata;
    logic [COUNT_BITS-1:0] w_rt_rdata;
    logic [COUNT_BITS-1:0] w_pc_wdata;
    logic [COUNT_BITS-1:0] w_rt_wdata;
    logic                w_clr_busy;
    logic                w_div_start;
    logic                w_div_done;
    logic [COUNT_BITS-1:0] w_div_rem;
    logic [RUN_W-1:0]    w_run_n;
    logic                w_issue;
    logic                w_a_ok;
    logic                w_b_ok;
    logic                w_accept;
    logic                w_out_load;

    assign o_in_ready  = (r_state == S_IDLE) && !w_clr_busy;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_a_ok      = 32'(i_in_data.first_letter) < 32'(ALPHABET);
    assign w_b_ok      = 32'(i_in_data.second_letter) < 32'(ALPHABET);

    // The output register takes a finished result once it is free or is
    // being emptied in the same cycle.
    assign w_out_load  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // The walk issues one row entry per cycle and checks the previous one.
    assign w_issue     = (r_state == S_WALK) && (32'(r_j) < 32'(ALPHABET));
    assign w_run_n     = r_run + RUN_W'(w_pc_rdata);

    assign w_row_addr  = RAW'(r_a);
    assign w_pc_addr   = (r_state == S_WALK) ? (r_base + AW'(r_j)) : (r_base + AW'(r_b));
    assign w_pc_wdata  = w_pc_rdata + 1'b1;
    assign w_rt_wdata  = w_rt_rdata + 1'b1;
    assign w_div_start = (r_state == S_RT) && (w_rt_rdata != '0);

    // A count writes back only when its row total still has room.
    always_comb begin
        w_ctl.rd = (r_state == S_ISSUE) || w_issue;
        w_ctl.wr = (r_state == S_RD) && (r_func == lbms_pkg::FUNC_COUNT)
                   && (w_rt_rdata != CNT_MAX);
    end

    lbms_table #(
        .ALPHABET   (ALPHABET),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_pc_addr  (w_pc_addr),
        .i_row_addr (w_row_addr),
        .i_pc_wdata (w_pc_wdata),
        .i_rt_wdata (w_rt_wdata),
        .o_pc_rdata (w_pc_rdata),
        .o_rt_rdata (w_rt_rdata),
        .o_clr_busy (w_clr_busy)
    );

    lbms_mod #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rnd),
        .i_divisor  (w_rt_rdata),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk_v     <= 1'b0;
        end else begin
            r_out_valid <= w_out_load || (r_out_valid && !i_out_ready);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func <= i_in_data.func;
                        r_a    <= i_in_data.first_letter;
                        r_b    <= i_in_data.second_letter;
                        r_rnd  <= i_in_data.random_value;
                        r_base <= AW'(32'(i_in_data.first_letter) * 32'(ALPHABET));
                        if ((i_in_data.func == lbms_pkg::FUNC_COUNT
                             || i_in_data.func == lbms_pkg::FUNC_READ) && w_a_ok && w_b_ok) begin
                            r_state <= S_ISSUE;
                        end else if (i_in_data.func == lbms_pkg::FUNC_SAMPLE && w_a_ok) begin
                            r_state <= S_ISSUE;
                        end else begin
                            r_res   <= lbms_pkg::t_out_item'({6'd0, 32'd0, 32'd0,
                                       (i_in_data.func == lbms_pkg::FUNC_SAMPLE)
                                       ? lbms_pkg::ST_EMPTY : lbms_pkg::ST_OK});
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= (r_func == lbms_pkg::FUNC_SAMPLE) ? S_RT : S_RD;
                end
                S_RD: begin
                    r_res.letter_out <= '0;
                    if (r_func == lbms_pkg::FUNC_COUNT && w_rt_rdata == CNT_MAX) begin
                        r_res.pair_count <= 32'(w_pc_rdata);
                        r_res.row_total  <= 32'(w_rt_rdata);
                        r_res.status     <= lbms_pkg::ST_SAT;
                    end else if (r_func == lbms_pkg::FUNC_COUNT) begin
                        r_res.pair_count <= 32'(w_pc_wdata);
                        r_res.row_total  <= 32'(w_rt_wdata);
                        r_res.status     <= lbms_pkg::ST_OK;
                    end else begin
                        r_res.pair_count <= 32'(w_pc_rdata);
                        r_res.row_total  <= 32'(w_rt_rdata);
                        r_res.status     <= lbms_pkg::ST_OK;
                    end
                    r_state <= S_EMIT;
                end
                S_RT: begin
                    if (w_rt_rdata == '0) begin
                        r_res   <= lbms_pkg::t_out_item'({6'd0, 32'd0, 32'd0,
                                   lbms_pkg::ST_EMPTY});
                        r_state <= S_EMIT;
                    end else begin
                        r_total <= w_rt_rdata;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_draw  <= w_div_rem;
                        r_j     <= '0;
                        r_run   <= '0;
                        r_chk_v <= 1'b0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_issue) begin
                        r_j <= r_j + 1'b1;
                    end
                    r_chk_v <= w_issue;
                    r_chk_j <= r_j[RAW-1:0];
                    if (r_chk_v) begin
                        r_run <= w_run_n;
                        if (w_run_n > {1'b0, r_draw}) begin
                            r_res.letter_out <= 6'(r_chk_j);
                            r_res.pair_count <= 32'(w_pc_rdata);
                            r_res.row_total  <= 32'(r_total);
                            r_res.status     <= lbms_pkg::ST_OK;
                            r_state          <= S_EMIT;
                        end else if (r_chk_j == RAW'(ALPHABET - 1)) begin
                            // Row sum fell short of the total; report as empty.
                            r_res.letter_out <= '0;
                            r_res.pair_count <= '0;
                            r_res.row_total  <= 32'(r_total);
                            r_res.status     <= lbms_pkg::ST_EMPTY;
                            r_state          <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LBMS_ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n,
        w_clr_busy, !o_in_ready, "item accepted during the clearing pass")
    `LBMS_ASSERT_SAME(a_wr_only_in_rd, i_clk, i_rst_n,
        w_ctl.wr, r_state == S_RD && !w_clr_busy, "table write outside read-modify-write")
    `LBMS_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n,
        w_div_done, r_state == S_DIV, "remainder finished outside its wait state")
    `LBMS_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n,
        r_state == S_EMIT && (!r_out_valid || i_out_ready),
        o_out_valid && r_state == S_IDLE, "result not loaded into output register")
    `LBMS_ASSERT_SAME(a_letter_implies_ok, i_clk, i_rst_n,
        o_out_valid && o_out_data.letter_out != '0,
        o_out_data.status == lbms_pkg::ST_OK, "sampled letter with error status")

endmodule

[bench/letter_bigram_markov_sampler_top_tb.sv]
`timescale 1ns / 1ps

module letter_bigram_markov_sampler_top_tb;

    import lbms_pkg::*;

    localparam int          ALPHA       = ALPHABET_DEF;
    localparam logic [31:0] CNT_MAX     = {32{1'b1}};
    // Drain time after the last result: longer than the longest sample.
    localparam int          DRAIN_WAIT  = 200;
    // The clearing pass plus ~1400 items, with idle gaps and stalls on both
    // sides, stays far below this.
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          PHASE_ITEMS = 425;

    // Shadow copy of the bigram table, which predicts one result per item.
    // Expected results wait in a queue in transfer order.
    class bigram_scoreboard;
        logic [31:0] pair_cnt [ALPHA*ALPHA];
        logic [31:0] row_tot  [ALPHA];
        t_out_item   pending_results [$];
        int unsigned mismatches;

        function new();
            foreach (pair_cnt[i]) pair_cnt[i] = '0;
            foreach (row_tot[i]) row_tot[i] = '0;
            mismatches = 0;
        endfunction

        // Applies one item to the shadow table and returns its result.
        function t_out_item predict_result(t_in_item it);
            t_out_item   r;
            int unsigned row;
            int unsigned idx;
            logic [31:0] total;
            logic [31:0] draw;
            logic [63:0] running;
            bit          found;
            r = '0;
            row = int'(it.first_letter);
            case (it.func)
                FUNC_COUNT, FUNC_READ: begin
                    if (it.first_letter < ALPHA && it.second_letter < ALPHA) begin
                        idx = row * ALPHA + int'(it.second_letter);
                        if (it.func == FUNC_COUNT && row_tot[row] == CNT_MAX) begin
                            // A full row drops the increment.
                            r.status = ST_SAT;
                        end else begin
                            if (it.func == FUNC_COUNT) begin
                                row_tot[row]  = row_tot[row] + 1'b1;
                                pair_cnt[idx] = pair_cnt[idx] + 1'b1;
                            end
                            r.status = ST_OK;
                        end
                        r.pair_count = pair_cnt[idx];
                        r.row_total  = row_tot[row];
                    end
                end
                FUNC_SAMPLE: begin
                    if (it.first_letter >= ALPHA || row_tot[row] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        total   = row_tot[row];
                        draw    = it.random_value % total;
                        running = '0;
                        found   = 1'b0;
                        for (int j = 0; j < ALPHA; j++) begin
                            if (!found) begin
                                running = running + {32'b0, pair_cnt[row*ALPHA + j]};
                                if (running > {32'b0, draw}) begin
                                    found        = 1'b1;
                                    r.letter_out = 6'(j);
                                    r.pair_count = pair_cnt[row*ALPHA + j];
                                end
                            end
                        end
                        r.row_total = total;
                        r.status    = found ? ST_OK : ST_EMPTY;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_transfer_in(t_in_item it);
            pending_results.push_back(predict_result(it));
        endfunction

        function void check_transfer_out(t_out_item got);
            t_out_item exp_res;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result: letter %0d pair %0d row %0d st %0d",
                             got.letter_out, got.pair_count, got.row_total, got.status);
            end else begin
                exp_res = pending_results.pop_front();
                if (got.letter_out !== exp_res.letter_out ||
                    got.pair_count !== exp_res.pair_count ||
                    got.row_total  !== exp_res.row_total  ||
                    got.status     !== exp_res.status) begin
                    mismatches++;
                    // Fields in order: letter, pair count, row total, status.
                    if (mismatches <= 10)
                        $display("ERROR: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 exp_res.letter_out, exp_res.pair_count,
                                 exp_res.row_total, exp_res.status,
                                 got.letter_out, got.pair_count,
                                 got.row_total, got.status);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    bigram_scoreboard sb;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      cycle_count = 0;

    letter_bigram_markov_sampler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog. The run normally ends long before this loop runs out.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("letter_bigram_markov_sampler_top verification failed");
        $finish;
    end

    // Result side. Signals read right after the edge still hold the values
    // that the edge sampled, since the block updates them in the NBA region.
    // A transfer is checked first, then ready is redrawn for the next cycle,
    // so ready gets exactly one assignment per edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_transfer_out(o_out_data);
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic t_in_item make_item(logic [1:0] func, logic [5:0] first,
                                           logic [5:0] second, logic [31:0] rnd);
        t_in_item it;
        it.func          = func;
        it.first_letter  = first;
        it.second_letter = second;
        it.random_value  = rnd;
        return it;
    endfunction

    // Offers one item, after an optional random idle gap, and holds it until
    // the transfer happens. Valid is only lowered when a gap is taken, so a
    // back-to-back item keeps valid high with a single assignment per edge.
    task automatic send_item(t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_transfer_in(it);
    endtask

    // The sender holds off until every expected result has been seen.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Random traffic. Most items are counts and samples on a handful of hot
    // rows, so that rows fill up with uneven counts and samples walk deep
    // into them. Noise items with any code and any letter index are mixed in
    // on top of the counted items.
    task automatic run_random_phase(int unsigned n_items);
        t_in_item    it;
        int unsigned kind;
        int unsigned counted;
        counted = 0;
        while (counted < n_items) begin
            kind = $urandom_range(0, 99);
            it.random_value = $urandom();
            if ($urandom_range(0, 15) == 0)
                it.random_value = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                it.first_letter = 6'($urandom_range(0, ALPHA - 1));
            else
                it.first_letter = 6'($urandom_range(ALPHA - 8, ALPHA - 1));
            if ($urandom_range(0, 1) == 0)
                it.second_letter = 6'($urandom_range(0, ALPHA - 1));
            else
                it.second_letter = 6'($urandom_range(0, 7));
            if (kind < 45) begin
                it.func = FUNC_COUNT;
            end else if (kind < 80) begin
                it.func = FUNC_SAMPLE;
            end else if (kind < 92) begin
                it.func = FUNC_READ;
            end else begin
                it.func          = 2'($urandom_range(0, 3));
                it.first_letter  = 6'($urandom_range(0, 63));
                it.second_letter = 6'($urandom_range(0, 63));
            end
            send_item(it);
            if (kind < 92)
                counted++;
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 24;
        recv_idle_pct = 52;

        // Synchronous reset first. The block then runs its
        // clearing pass; the first item simply waits on o_in_ready.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a fresh table reads as zero and samples as empty.
        send_item(make_item(FUNC_READ,   6'd0,  6'd0,  32'd0));
        send_item(make_item(FUNC_SAMPLE, 6'd0,  6'd0,  32'hFFFF_FFFF));
        // Corner letters of the alphabet.
        send_item(make_item(FUNC_COUNT,  6'd0,  6'd0,  32'd0));
        send_item(make_item(FUNC_COUNT,  6'd0,  6'd51, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_COUNT,  6'd51, 6'd0,  32'd0));
        send_item(make_item(FUNC_COUNT,  6'd51, 6'd51, 32'd0));
        send_item(make_item(FUNC_COUNT,  6'd0,  6'd51, 32'd0));
        send_item(make_item(FUNC_READ,   6'd0,  6'd51, 32'd0));
        send_item(make_item(FUNC_READ,   6'd51, 6'd51, 32'hFFFF_FFFF));
        // Row 0 holds one A and two z: draws at both ends of the range and
        // right on the boundary between the two letters.
        send_item(make_item(FUNC_SAMPLE, 6'd0,  6'd0,  32'd0));
        send_item(make_item(FUNC_SAMPLE, 6'd0,  6'd63, 32'd1));
        send_item(make_item(FUNC_SAMPLE, 6'd0,  6'd0,  32'd2));
        send_item(make_item(FUNC_SAMPLE, 6'd0,  6'd0,  32'hFFFF_FFFF));
        send_item(make_item(FUNC_SAMPLE, 6'd0,  6'd0,  32'hFFFF_FFFE));
        // A row whose only entry sits behind many zero counts.
        send_item(make_item(FUNC_COUNT,  6'd5,  6'd40, 32'd0));
        send_item(make_item(FUNC_SAMPLE, 6'd5,  6'd0,  32'h8000_0000));
        // Letters out of range change nothing; a sample there is empty.
        send_item(make_item(FUNC_COUNT,  6'd52, 6'd0,  32'd0));
        send_item(make_item(FUNC_COUNT,  6'd0,  6'd63, 32'd0));
        send_item(make_item(FUNC_READ,   6'd63, 6'd63, 32'd0));
        send_item(make_item(FUNC_SAMPLE, 6'd63, 6'd63, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_SAMPLE, 6'd52, 6'd0,  32'd0));
        // The unused function code returns all zero.
        send_item(make_item(2'd3,        6'd63, 6'd63, 32'hFFFF_FFFF));
        send_item(make_item(2'd3,        6'd0,  6'd0,  32'd0));
        send_item(make_item(FUNC_READ,   6'd0,  6'd0,  32'd0));

        // Three random phases with the idle rates swapped and then off. The
        // sender drains the block between phases.
        run_random_phase(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 52;
        recv_idle_pct = 24;
        run_random_phase(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);

        // Wait for the last results, then give the block time to show any
        // stray extra transfer.
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("letter_bigram_markov_sampler_top verification clean");
        else
            $display("letter_bigram_markov_sampler_top verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lbms_pkg.sv
src/lbms_table.sv
src/lbms_mod.sv
src/letter_bigram_markov_sampler_top.sv
bench/letter_bigram_markov_sampler_top_tb.sv
